>>> rtl/core/mspd_pkg.sv
package mspd_pkg;

    localparam int SYNC_MAX_LEN = 4;
    localparam int HEADER_LEN   = 3;

    // pattern register holds at most four sync bytes
    localparam int SYNC_CAP = (SYNC_MAX_LEN < 4) ? SYNC_MAX_LEN : 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] HDR_LAST = 2'(HEADER_LEN - 1);

    typedef enum logic [1:0] {
        KIND_STRAY   = 2'd0,
        KIND_HDR_OK  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_HDR_REJ = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0] sync_pattern;
        logic [2:0]  sync_length;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [7:0]  message_type;
        logic [15:0] payload_length;
        logic [15:0] byte_offset;
        logic        last;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> rtl/core/mspd_front.sv
module mspd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  mspd_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  mspd_pkg::q_stat_t q_stat,
    output logic              push,
    output mspd_pkg::result_t push_data
);

    mspd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  match_index_reg, match_index_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] payload_count_reg, payload_count_next;

    logic        accept;
    logic [2:0]  sync_len;
    logic [2:0]  hunt_idx;
    logic [7:0]  expect_byte;
    logic        sync_hit;
    logic        sync_done;
    logic [15:0] hdr_len;
    logic        oversize;
    logic        hdr_last;
    logic [16:0] off_inc;
    logic        pay_fin;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // effective sync length saturates to 1..cap
    assign sync_len = (cfg.sync_length == 3'd0) ? 3'd1 :
                      (cfg.sync_length > 3'(mspd_pkg::SYNC_CAP)) ? 3'(mspd_pkg::SYNC_CAP) :
                      cfg.sync_length;

    // restart the compare if the length shrank under the current index
    assign hunt_idx = (match_index_reg >= sync_len) ? 3'd0 : match_index_reg;

    always_comb
    begin
        case (hunt_idx[1:0])
            2'd0:    expect_byte = cfg.sync_pattern[31:24];
            2'd1:    expect_byte = cfg.sync_pattern[23:16];
            2'd2:    expect_byte = cfg.sync_pattern[15:8];
            default: expect_byte = cfg.sync_pattern[7:0];
        endcase
    end

    assign sync_hit  = (in_byte == expect_byte);
    assign sync_done = ((hunt_idx + 3'd1) >= sync_len);

    assign hdr_len   = {held_length_reg[15:8], in_byte};
    assign oversize  = (hdr_len > cfg.max_payload);
    assign hdr_last  = (header_count_reg == mspd_pkg::HDR_LAST);

    assign off_inc   = {1'b0, payload_count_reg} + 17'd1;
    assign pay_fin   = (off_inc >= {1'b0, held_length_reg});

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            mspd_pkg::PH_HEADER:
            begin
                if (accept && hdr_last)
                begin
                    phase_next = (oversize || hdr_len == 16'd0) ? mspd_pkg::PH_HUNT
                                                                : mspd_pkg::PH_PAYLOAD;
                end
            end
            mspd_pkg::PH_PAYLOAD:
            begin
                if (accept && pay_fin)
                begin
                    phase_next = mspd_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = mspd_pkg::PH_HUNT;
                if (accept && sync_hit && sync_done)
                begin
                    phase_next = mspd_pkg::PH_HEADER;
                end
            end
        endcase
    end

    always_comb
    begin
        match_index_next   = match_index_reg;
        header_count_next  = header_count_reg;
        held_type_next     = held_type_reg;
        held_length_next   = held_length_reg;
        payload_count_next = payload_count_reg;
        push               = 1'b0;
        push_data          = '0;

        if (accept)
        begin
            unique case (phase_reg)
                mspd_pkg::PH_HEADER:
                begin
                    if (hdr_last)
                    begin
                        held_length_next         = hdr_len;
                        header_count_next        = 2'd0;
                        payload_count_next       = 16'd0;
                        push                     = 1'b1;
                        push_data.kind           = oversize ? mspd_pkg::KIND_HDR_REJ
                                                            : mspd_pkg::KIND_HDR_OK;
                        push_data.message_type   = held_type_reg;
                        push_data.payload_length = hdr_len;
                        push_data.last           = oversize || (hdr_len == 16'd0);
                    end
                    else if (header_count_reg == 2'd0)
                    begin
                        held_type_next    = in_byte;
                        header_count_next = 2'd1;
                    end
                    else
                    begin
                        held_length_next  = {in_byte, 8'h00};
                        header_count_next = header_count_reg + 2'd1;
                    end
                end
                mspd_pkg::PH_PAYLOAD:
                begin
                    push                     = 1'b1;
                    push_data.kind           = mspd_pkg::KIND_PAYLOAD;
                    push_data.data_byte      = in_byte;
                    push_data.message_type   = held_type_reg;
                    push_data.payload_length = held_length_reg;
                    push_data.byte_offset    = payload_count_reg;
                    push_data.last           = pay_fin;
                    payload_count_next       = pay_fin ? 16'd0 : off_inc[15:0];
                end
                default:
                begin
                    if (sync_hit)
                    begin
                        if (sync_done)
                        begin
                            match_index_next  = 3'd0;
                            header_count_next = 2'd0;
                        end
                        else
                        begin
                            match_index_next = hunt_idx + 3'd1;
                        end
                    end
                    else
                    begin
                        match_index_next    = 3'd0;
                        push                = 1'b1;
                        push_data.kind      = mspd_pkg::KIND_STRAY;
                        push_data.data_byte = in_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mspd_pkg::PH_HUNT;
            match_index_reg   <= '0;
            header_count_reg  <= '0;
            held_type_reg     <= '0;
            held_length_reg   <= '0;
            payload_count_reg <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            match_index_reg   <= match_index_next;
            header_count_reg  <= header_count_next;
            held_type_reg     <= held_type_next;
            held_length_reg   <= held_length_next;
            payload_count_reg <= payload_count_next;
        end
    end

endmodule

>>> rtl/core/mspd_queue.sv
module mspd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mspd_pkg::result_t push_data,
    input  logic              pop,
    output mspd_pkg::result_t pop_data,
    output mspd_pkg::q_stat_t q_stat
);

    mspd_pkg::result_t mem [mspd_pkg::QUEUE_DEPTH];

    logic [mspd_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mspd_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mspd_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign q_stat.full  = (count_reg == mspd_pkg::Q_CNT_W'(mspd_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    assign wr_ptr_next = do_push ? wr_ptr_reg + mspd_pkg::Q_PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + mspd_pkg::Q_PTR_W'(1) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + mspd_pkg::Q_CNT_W'(1);
            2'b01:   count_next = count_reg - mspd_pkg::Q_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/mspd_back.sv
module mspd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  mspd_pkg::q_stat_t q_stat,
    input  mspd_pkg::result_t pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output mspd_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    mspd_pkg::result_t out_data_reg;
    logic              load;

    // refill the output register whenever it is empty or being drained
    assign load           = !q_stat.empty && (!out_valid_reg || out_ready);
    assign pop            = load;
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= pop_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/magic_sync_packet_deframer.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata[7:0] rx_byte
// m_*       out  m_tvalid/m_tready   m_tdata, m_tuser kind, m_tlast last
// APB       in   psel/penable        sync_pattern @0x0, sync_length @0x4, max_payload @0x8
//
// One byte is taken per cycle while s_tready is high; the front updates its
// hunt/header/payload state in the cycle of acceptance and posts any result into a
// 4-entry queue, from which the output register on m_tdata is refilled.
// s_tready drops only while the queue is full, i.e. after five stalled results
// (one in the output register, four queued).
// Reset returns to hunting with match, header and payload counters cleared.
module magic_sync_packet_deframer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] data_byte, [15:8] message_type,
                                   // [31:16] payload_length, [47:32] byte_offset
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
    localparam logic [1:0] REG_SYNC_LENGTH  = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

    logic [31:0] sync_pattern_reg, sync_pattern_next;
    logic [2:0]  sync_length_reg, sync_length_next;
    logic [15:0] max_payload_reg, max_payload_next;
    logic        cfg_write;

    mspd_pkg::cfg_t    cfg;
    mspd_pkg::q_stat_t q_stat;
    mspd_pkg::result_t push_data;
    mspd_pkg::result_t pop_data;
    mspd_pkg::result_t out_data;
    logic              push;
    logic              pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        sync_pattern_next = sync_pattern_reg;
        sync_length_next  = sync_length_reg;
        max_payload_next  = max_payload_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_SYNC_PATTERN: sync_pattern_next = pwdata;
                REG_SYNC_LENGTH:  sync_length_next  = pwdata[2:0];
                REG_MAX_PAYLOAD:  max_payload_next  = pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SYNC_PATTERN: prdata = sync_pattern_reg;
            REG_SYNC_LENGTH:  prdata = {29'd0, sync_length_reg};
            REG_MAX_PAYLOAD:  prdata = {16'd0, max_payload_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= 32'd0;
            sync_length_reg  <= 3'd4;
            max_payload_reg  <= 16'hFFFF;
        end
        else
        begin
            sync_pattern_reg <= sync_pattern_next;
            sync_length_reg  <= sync_length_next;
            max_payload_reg  <= max_payload_next;
        end
    end

    assign cfg.sync_pattern = sync_pattern_reg;
    assign cfg.sync_length  = sync_length_reg;
    assign cfg.max_payload  = max_payload_reg;

    mspd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    mspd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    mspd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.byte_offset, out_data.payload_length,
                      out_data.message_type, out_data.data_byte};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

>>> rtl/core/mspd_checker.sv
module mspd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_stray_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mspd_pkg::KIND_STRAY |->
            !m_tlast && m_tdata[47:8] == 40'd0)
        else $error("stray byte with header fields or last");

    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mspd_pkg::KIND_HDR_REJ |->
            m_tlast && m_tdata[7:0] == 8'd0 && m_tdata[47:32] == 16'd0)
        else $error("rejected header malformed");

    // last payload byte is the one at offset length-1
    a_payload_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mspd_pkg::KIND_PAYLOAD |->
            m_tlast == (({1'b0, m_tdata[47:32]} + 17'd1) >= {1'b0, m_tdata[31:16]}))
        else $error("payload last flag mismatches offset");

endmodule

bind magic_sync_packet_deframer mspd_checker u_mspd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYC       = 11;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYC        = 400;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYC      = 8;

    localparam logic [3:0] ADDR_SYNC_PATTERN = 4'h0;
    localparam logic [3:0] ADDR_SYNC_LENGTH  = 4'h4;
    localparam logic [3:0] ADDR_MAX_PAYLOAD  = 4'h8;
    localparam logic [3:0] ADDR_UNMAPPED     = 4'hC;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the register file
    logic [31:0] sync_pat_q = 32'h0;
    logic [2:0]  sync_len_q = 3'd4;
    logic [15:0] max_pay_q  = 16'hFFFF;

    // shadow of the deframer state
    mspd_pkg::phase_t rx_phase  = mspd_pkg::PH_HUNT;
    logic [2:0]       match_idx = 3'd0;
    logic [1:0]       hdr_cnt   = 2'd0;
    logic [7:0]       hdr_type  = 8'h00;
    logic [15:0]      hdr_len   = 16'h0;
    logic [15:0]      pay_cnt   = 16'h0;

    logic [7:0]        rx_bytes[$];     // requests not yet offered
    mspd_pkg::result_t deframed_q[$];   // predicted results not yet seen

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          rx_hold_on     = 1'b0;
    bit          rx_hold_done   = 1'b0;
    int unsigned hold_cnt       = 0;
    int unsigned errors         = 0;
    int unsigned cycles         = 0;

    magic_sync_packet_deframer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int unsigned sync_len_eff();
        int unsigned n;
        n = sync_len_q;
        if (n < 1)
            n = 1;
        if (n > mspd_pkg::SYNC_CAP)
            n = mspd_pkg::SYNC_CAP;
        return n;
    endfunction

    function automatic logic [7:0] sync_byte(input int unsigned i);
        return sync_pat_q[31 - 8 * i -: 8];
    endfunction

    function automatic mspd_pkg::result_t mk_result(input mspd_pkg::kind_t k,
                                                    input logic [7:0] d,
                                                    input logic [7:0] t,
                                                    input logic [15:0] len,
                                                    input logic [15:0] off,
                                                    input logic lst);
        mspd_pkg::result_t r;
        r.kind           = k;
        r.data_byte      = d;
        r.message_type   = t;
        r.payload_length = len;
        r.byte_offset    = off;
        r.last           = lst;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        int unsigned n;
        int unsigned idx;
        logic [16:0] next_off;
        logic        fin;
        case (rx_phase)
            mspd_pkg::PH_HEADER:
            begin
                if (hdr_cnt == 2'd0)
                begin
                    hdr_type = b;
                    hdr_cnt  = 2'd1;
                end
                else if (hdr_cnt == 2'd1)
                begin
                    hdr_len = {b, 8'h00};
                    hdr_cnt = 2'd2;
                end
                else
                begin
                    hdr_len[7:0] = b;
                    hdr_cnt      = 2'd0;
                    pay_cnt      = 16'h0;
                    if (hdr_len > max_pay_q)
                    begin
                        rx_phase = mspd_pkg::PH_HUNT;
                        deframed_q.push_back(mk_result(mspd_pkg::KIND_HDR_REJ, 8'h00,
                                                       hdr_type, hdr_len, 16'h0, 1'b1));
                    end
                    else if (hdr_len == 16'h0)
                    begin
                        rx_phase = mspd_pkg::PH_HUNT;
                        deframed_q.push_back(mk_result(mspd_pkg::KIND_HDR_OK, 8'h00,
                                                       hdr_type, 16'h0, 16'h0, 1'b1));
                    end
                    else
                    begin
                        rx_phase = mspd_pkg::PH_PAYLOAD;
                        deframed_q.push_back(mk_result(mspd_pkg::KIND_HDR_OK, 8'h00,
                                                       hdr_type, hdr_len, 16'h0, 1'b0));
                    end
                end
            end
            mspd_pkg::PH_PAYLOAD:
            begin
                next_off = {1'b0, pay_cnt} + 17'd1;
                fin      = (next_off >= {1'b0, hdr_len});
                deframed_q.push_back(mk_result(mspd_pkg::KIND_PAYLOAD, b, hdr_type,
                                               hdr_len, pay_cnt, fin));
                pay_cnt = next_off[15:0];
                if (fin)
                begin
                    rx_phase = mspd_pkg::PH_HUNT;
                    pay_cnt  = 16'h0;
                end
            end
            default:
            begin
                n        = sync_len_eff();
                idx      = match_idx;
                rx_phase = mspd_pkg::PH_HUNT;
                // a shortened pattern restarts the compare
                if (idx >= n)
                    idx = 0;
                if (b == sync_byte(idx))
                begin
                    idx++;
                    if (idx >= n)
                    begin
                        match_idx = 3'd0;
                        hdr_cnt   = 2'd0;
                        rx_phase  = mspd_pkg::PH_HEADER;
                    end
                    else
                        match_idx = 3'(idx);
                end
                else
                begin
                    match_idx = 3'd0;
                    deframed_q.push_back(mk_result(mspd_pkg::KIND_STRAY, b, 8'h00,
                                                   16'h0, 16'h0, 1'b0));
                end
            end
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        mspd_pkg::result_t want;
        if (deframed_q.size() == 0)
        begin
            $error("unexpected result: kind %0d data %0h", m_tuser, m_tdata[7:0]);
            errors++;
        end
        else
        begin
            want = deframed_q.pop_front();
            cmp_field("kind", 16'(want.kind), 16'(m_tuser));
            cmp_field("data_byte", 16'(want.data_byte), 16'(m_tdata[7:0]));
            cmp_field("message_type", 16'(want.message_type), 16'(m_tdata[15:8]));
            cmp_field("payload_length", want.payload_length, m_tdata[31:16]);
            cmp_field("byte_offset", want.byte_offset, m_tdata[47:32]);
            cmp_field("last", 16'(want.last), 16'(m_tlast));
        end
    endtask

    // request driver: prediction runs at the accepting edge
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (rx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= !(rx_hold_on && !rx_hold_done)
                        && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the output queue fills and s_tready drops
    always @(posedge clk)
    begin
        if (rx_hold_on && !rx_hold_done)
        begin
            if (hold_cnt == HOLD_CYC - 1)
                rx_hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[magic_sync_packet_deframer] ERROR");
            $finish;
        end
    end

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_SYNC_PATTERN: sync_pat_q = value;
            ADDR_SYNC_LENGTH:  sync_len_q = value[2:0];
            ADDR_MAX_PAYLOAD:  max_pay_q  = value[15:0];
            default: ;
        endcase
    endtask

    // all requests taken and all results seen, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (rx_bytes.size() != 0 || s_tvalid || deframed_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic add_sync(input int unsigned upto);
        for (int unsigned i = 0; i < upto; i++)
            rx_bytes.push_back(sync_byte(i));
    endtask

    task automatic add_packet(input logic [7:0] mtype, input logic [15:0] len);
        add_sync(sync_len_eff());
        rx_bytes.push_back(mtype);
        rx_bytes.push_back(len[15:8]);
        rx_bytes.push_back(len[7:0]);
        if (len <= max_pay_q)
            repeat (len) rx_bytes.push_back(8'($urandom));
    endtask

    task automatic add_random_traffic(input int unsigned n_items);
        int unsigned r;
        int unsigned cap;
        int unsigned k;
        logic [15:0] len;
        while (rx_bytes.size() < n_items)
        begin
            r = $urandom_range(99);
            if (r < 75)
            begin
                cap = (max_pay_q < 12) ? max_pay_q : 12;
                if ($urandom_range(9) == 0)
                    cap = (max_pay_q < 40) ? max_pay_q : 40;
                len = 16'($urandom_range(cap));
                if (max_pay_q != 16'hFFFF && $urandom_range(7) == 0)
                    len = 16'($urandom_range(32'(max_pay_q) + 1, 65535));
                add_packet(8'($urandom), len);
            end
            else if (r < 87)
            begin
                // sync cut short by a wrong byte
                k = $urandom_range(sync_len_eff() - 1);
                add_sync(k);
                rx_bytes.push_back(sync_byte(k) ^ 8'($urandom_range(1, 255)));
            end
            else
                repeat ($urandom_range(1, 3)) rx_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input logic [31:0] pattern, input logic [31:0] len,
                             input logic [15:0] maxp, input bit hold);
        reg_write(ADDR_SYNC_PATTERN, pattern);
        reg_write(ADDR_SYNC_LENGTH, len);
        reg_write(ADDR_MAX_PAYLOAD, 32'(maxp));
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        rx_hold_on     = hold;
        add_random_traffic(ITEMS_PER_PHASE);
        wait_idle();
        rx_hold_on = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        reg_write(ADDR_SYNC_PATTERN, 32'hA5C3_0F7E);
        reg_write(ADDR_MAX_PAYLOAD, 32'd16);
        @(negedge clk);
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        add_packet(8'hFF, 16'd0);         // empty packet ends at the header
        add_packet(8'h00, 16'd3);
        add_packet(8'h81, 16'hFFFF);      // oversize
        add_packet(8'h42, 16'd17);        // one past the limit
        add_sync(2);
        rx_bytes.push_back(8'h00);        // wrong third sync byte
        add_sync(3);                      // hunt left three bytes in
        wait_idle();

        // shrink the pattern below the match index; upper data bits are dropped
        reg_write(ADDR_SYNC_LENGTH, 32'hFFFF_FFFA);
        reg_write(ADDR_MAX_PAYLOAD, 32'h0);
        reg_write(ADDR_UNMAPPED, 32'h0000_00FF);
        @(negedge clk);
        add_packet(8'h5A, 16'd0);
        add_packet(8'hA5, 16'd1);
        wait_idle();

        // sync length zero acts as one
        reg_write(ADDR_SYNC_PATTERN, 32'hFFFF_FFFF);
        reg_write(ADDR_SYNC_LENGTH, 32'd0);
        reg_write(ADDR_MAX_PAYLOAD, 32'h0000_FFFF);
        @(negedge clk);
        add_packet(8'h3C, 16'd64);
        wait_idle();

        run_phase(0, 0, $urandom, 32'd4, 16'hFFFF, 1'b0);
        run_phase(61, 0, $urandom, 32'd1, 16'd12, 1'b0);
        run_phase(0, 61, 32'h0000_0000, 32'd7, 16'd40, 1'b0);
        run_phase(8, 8, 32'hFFFF_FFFF, 32'd3, 16'd5, 1'b0);
        run_phase(0, 0, $urandom, 32'd2, 16'd20, 1'b1);

        if (errors == 0)
            $display("[magic_sync_packet_deframer] OK");
        else
            $display("[magic_sync_packet_deframer] ERROR");
        $finish;
    end

endmodule
